FILE: design/ibanv_pkg.sv
// Shared constants, error codes and mod-97 helper functions for the IBAN validator.
package ibanv_pkg;

  // Result error codes
  localparam logic [2:0] ERR_OK           = 3'd0;
  localparam logic [2:0] ERR_SHORT        = 3'd1;
  localparam logic [2:0] ERR_COUNTRY      = 3'd2;
  localparam logic [2:0] ERR_CHECK_DIGITS = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN      = 3'd4;
  localparam logic [2:0] ERR_LENGTH       = 3'd5;
  localparam logic [2:0] ERR_BAD_CHAR     = 3'd6;
  localparam logic [2:0] ERR_CHECKSUM     = 3'd7;

  localparam int          MOD_BASE  = 97;
  localparam logic [5:0]  MIN_LEN   = 6'd15;
  localparam logic [5:0]  COUNT_MAX = 6'd63;
  localparam logic [5:0]  HEAD_LEN  = 6'd4;
  // 2^10 mod 97, used to fold the top bits of the final sum
  localparam logic [10:0] POW10_MOD = 11'd54;
  // Largest multiple count needed to cover an 11-bit value
  localparam int          FOLD_STEPS = 2047 / MOD_BASE;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Reduce an 11-bit value modulo 97 with parallel threshold compares
  function automatic logic [6:0] mod97_reduce(input logic [10:0] t);
    logic [10:0] m;
    m = '0;
    for (int k = 1; k <= FOLD_STEPS; k++) begin
      if (t >= 11'(k * MOD_BASE)) m = 11'(k * MOD_BASE);
    end
    return 7'(t - m);
  endfunction

  // IBAN length by country; zero when the country is not listed
  function automatic logic [5:0] country_len(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] len;
    case ({a, b})
      "AD": len = 6'd24;  "AE": len = 6'd23;  "AL": len = 6'd28;  "AT": len = 6'd20;
      "AZ": len = 6'd28;  "BA": len = 6'd20;  "BE": len = 6'd16;  "BG": len = 6'd22;
      "BH": len = 6'd22;  "BR": len = 6'd29;  "BY": len = 6'd28;  "CH": len = 6'd21;
      "CR": len = 6'd22;  "CY": len = 6'd28;  "CZ": len = 6'd24;  "DE": len = 6'd22;
      "DK": len = 6'd18;  "DO": len = 6'd28;  "EE": len = 6'd20;  "EG": len = 6'd29;
      "ES": len = 6'd24;  "FI": len = 6'd18;  "FO": len = 6'd18;  "FR": len = 6'd27;
      "GB": len = 6'd22;  "GE": len = 6'd22;  "GI": len = 6'd23;  "GL": len = 6'd18;
      "GR": len = 6'd27;  "GT": len = 6'd28;  "HR": len = 6'd21;  "HU": len = 6'd28;
      "IE": len = 6'd22;  "IL": len = 6'd23;  "IS": len = 6'd26;  "IT": len = 6'd27;
      "JO": len = 6'd30;  "KW": len = 6'd30;  "KZ": len = 6'd20;  "LB": len = 6'd28;
      "LC": len = 6'd32;  "LI": len = 6'd21;  "LT": len = 6'd20;  "LU": len = 6'd20;
      "LV": len = 6'd21;  "MC": len = 6'd27;  "MD": len = 6'd24;  "ME": len = 6'd22;
      "MK": len = 6'd19;  "MR": len = 6'd27;  "MT": len = 6'd31;  "MU": len = 6'd30;
      "NL": len = 6'd18;  "NO": len = 6'd15;  "PK": len = 6'd24;  "PL": len = 6'd28;
      "PS": len = 6'd29;  "PT": len = 6'd25;  "QA": len = 6'd29;  "RO": len = 6'd24;
      "RS": len = 6'd22;  "SA": len = 6'd24;  "SE": len = 6'd24;  "SI": len = 6'd19;
      "SK": len = 6'd24;  "SM": len = 6'd27;  "TN": len = 6'd24;  "TR": len = 6'd26;
      "UA": len = 6'd29;  "VA": len = 6'd22;  "VG": len = 6'd24;  "XK": len = 6'd20;
      default: len = 6'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: design/ibanv_if.sv
// Valid/ready channel interfaces for IBAN characters in and check results out.
interface ibanv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface ibanv_res_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [2:0] error_code;
  logic [6:0] remainder_out;

  modport source (output valid, output valid_res, output error_code,
                  output remainder_out, input ready);
  modport sink   (input valid, input valid_res, input error_code,
                  input remainder_out, output ready);
endinterface

FILE: design/iban_mod97_validator_core.sv
// IBAN mod 97-10 validator: byte stream in, one check result per IBAN out.
//
// in_ch carries one ASCII byte per transfer with last marking the final byte
// of an IBAN. Whitespace is skipped, lower case is folded to upper case.
// out_ch carries one result per IBAN: valid_res, error_code, remainder_out.
// Three register stages: input register (per-byte state update), a snapshot
// register taken at the last byte (checks and final remainder fold), and
// the output register. out_ch.valid rises once the last byte has passed
// through all three. One byte per cycle is sustained while in_ch.ready is high;
// the per-byte modulo update is a combinational small add and threshold
// reduction, so the input register takes a new byte as it hands one on.
// When out_ch stalls, a pending result waits in the output register and a
// second one in the snapshot stage; bytes that are not last keep flowing.
// in_ch.ready only drops when a last byte sits in the input register, both
// later stages hold results and out_ch.ready is low.
// Reset (rst_n low, synchronous) empties all stages and clears the running
// count, remainder and bad-character flag; after each last byte the block
// returns to that same cleared state for the next IBAN.
module iban_mod97_validator_core
  import ibanv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ibanv_char_if.sink   in_ch,
  ibanv_res_if.source  out_ch
);

  // Stage A: input register
  logic       a_vld_r;
  logic [7:0] a_char_r;
  logic       a_last_r;

  // Per-IBAN running state
  logic [7:0] head_r [4];
  logic [5:0] cnt_r;
  logic [6:0] rem_r;
  logic       bad_r;

  logic [7:0] head_nxt [4];
  logic [5:0] cnt_nxt;
  logic [6:0] rem_nxt;
  logic       bad_nxt;

  // Stage B: snapshot at the last byte
  logic       b_vld_r;
  logic [7:0] b_head_r [4];
  logic [5:0] b_cnt_r;
  logic [6:0] b_rem_r;
  logic       b_bad_r;

  // Output register
  logic       o_vld_r;
  logic       o_ok_r;
  logic [2:0] o_err_r;
  logic [6:0] o_rem_r;

  // Flow control
  logic c_free, b_free, a_go, a_free;

  assign c_free      = !o_vld_r || out_ch.ready;
  assign b_free      = !b_vld_r || c_free;
  assign a_go        = a_vld_r && (!a_last_r || b_free);
  assign a_free      = !a_vld_r || a_go;
  assign in_ch.ready = a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_free) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_char_r <= in_ch.char_code;
      a_last_r <= in_ch.last;
    end
  end

  // Byte classification and case folding
  logic       a_space, a_let, a_dig;
  logic [7:0] a_up;
  logic [3:0] a_dval;
  logic [5:0] a_lval;
  logic [10:0] a_sum;

  always_comb begin
    a_space = ((a_char_r >= 8'd9) && (a_char_r <= 8'd13)) || (a_char_r == 8'd32);
    a_up    = ((a_char_r >= 8'h61) && (a_char_r <= 8'h7A)) ? a_char_r - 8'd32 : a_char_r;
    a_let   = is_letter(a_up);
    a_dig   = is_digit(a_up);
    a_dval  = 4'(a_up - 8'h30);
    a_lval  = 6'(a_up - 8'd55);
    // digit: r*10 + d, letter: r*100 + v == r*3 + v (mod 97)
    if (a_dig) begin
      a_sum = 11'({rem_r, 3'b000}) + 11'({rem_r, 1'b0}) + 11'(a_dval);
    end else begin
      a_sum = 11'(rem_r) + 11'({rem_r, 1'b0}) + 11'(a_lval);
    end
  end

  // Next running state for a kept byte
  always_comb begin
    for (int i = 0; i < 4; i++) head_nxt[i] = head_r[i];
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    bad_nxt = bad_r;
    if (!a_space) begin
      if (cnt_r < HEAD_LEN) begin
        head_nxt[cnt_r[1:0]] = a_up;
      end else begin
        if (!a_let && !a_dig) bad_nxt = 1'b1;
        if (a_let || a_dig) rem_nxt = mod97_reduce(a_sum);
      end
      if (cnt_r < COUNT_MAX) cnt_nxt = cnt_r + 6'd1;
    end
  end

  // Running state registers; cleared after every last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rem_r <= '0;
      bad_r <= 1'b0;
    end else if (a_go) begin
      if (a_last_r) begin
        cnt_r <= '0;
        rem_r <= '0;
        bad_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        rem_r <= rem_nxt;
        bad_r <= bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && !a_last_r) begin
      for (int i = 0; i < 4; i++) head_r[i] <= head_nxt[i];
    end
  end

  // Snapshot stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_free) begin
      b_vld_r <= a_go && a_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_go && a_last_r) begin
      for (int i = 0; i < 4; i++) b_head_r[i] <= head_nxt[i];
      b_cnt_r <= cnt_nxt;
      b_rem_r <= rem_nxt;
      b_bad_r <= bad_nxt;
    end
  end

  // Final fold: rem*10^6 + head digits, 10^6 == 27 and 10^4 == 9 (mod 97)
  logic [5:0]  b_clen;
  logic [11:0] b_x;
  logic [10:0] b_xf;
  logic [6:0]  b_final;
  logic [2:0]  b_err;
  logic [6:0]  b_rem_out;
  logic [5:0]  b_av, b_bv;
  logic [3:0]  b_cd, b_dd;

  always_comb begin
    b_av   = 6'(b_head_r[0] - 8'd55);
    b_bv   = 6'(b_head_r[1] - 8'd55);
    b_cd   = 4'(b_head_r[2] - 8'h30);
    b_dd   = 4'(b_head_r[3] - 8'h30);
    b_x    = 12'({b_rem_r, 4'b0000}) + 12'({b_rem_r, 3'b000}) + 12'({b_rem_r, 1'b0})
           + 12'(b_rem_r)
           + 12'({b_av, 3'b000}) + 12'(b_av)
           + 12'({b_bv, 1'b0}) + 12'(b_bv)
           + 12'({b_cd, 3'b000}) + 12'({b_cd, 1'b0}) + 12'(b_dd);
    b_xf   = 11'(b_x[11:10]) * POW10_MOD + 11'(b_x[9:0]);
    b_final = mod97_reduce(b_xf);
    b_clen = country_len(b_head_r[0], b_head_r[1]);

    // Checks in priority order
    b_rem_out = '0;
    if (b_cnt_r < MIN_LEN) begin
      b_err = ERR_SHORT;
    end else if (!is_letter(b_head_r[0]) || !is_letter(b_head_r[1])) begin
      b_err = ERR_COUNTRY;
    end else if (!is_digit(b_head_r[2]) || !is_digit(b_head_r[3])) begin
      b_err = ERR_CHECK_DIGITS;
    end else if (b_clen == 6'd0) begin
      b_err = ERR_UNKNOWN;
    end else if (b_cnt_r != b_clen) begin
      b_err = ERR_LENGTH;
    end else if (b_bad_r) begin
      b_err = ERR_BAD_CHAR;
    end else begin
      b_rem_out = b_final;
      b_err     = (b_final == 7'd1) ? ERR_OK : ERR_CHECKSUM;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (c_free) begin
      o_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free && b_vld_r) begin
      o_ok_r  <= (b_err == ERR_OK);
      o_err_r <= b_err;
      o_rem_r <= b_rem_out;
    end
  end

  assign out_ch.valid         = o_vld_r;
  assign out_ch.valid_res     = o_ok_r;
  assign out_ch.error_code    = o_err_r;
  assign out_ch.remainder_out = o_rem_r;

  // Running remainder is always a proper residue
  assert property (@(posedge clk) disable iff (!rst_n) rem_r < 7'(MOD_BASE))
    else $error("running remainder out of range");

  // State is cleared once a last byte is consumed
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_last_r) |=> (cnt_r == '0 && rem_r == '0 && !bad_r))
    else $error("state not cleared after last byte");

  // Pass flag agrees with the error code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.valid_res == (out_ch.error_code == ERR_OK)))
    else $error("valid_res inconsistent with error_code");

  // No remainder is reported for errors found before the checksum step
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error_code != ERR_OK && out_ch.error_code != ERR_CHECKSUM)
      |-> (out_ch.remainder_out == '0))
    else $error("remainder reported for an early error");

endmodule
